>>> hw/rtl/settable_clock_seven_segment_mux_assert.svh
`ifndef SETTABLE_CLOCK_SEVEN_SEGMENT_MUX_ASSERT_SVH
`define SETTABLE_CLOCK_SEVEN_SEGMENT_MUX_ASSERT_SVH

// same-cycle implication
`define SSCM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSCM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/sscm_pkg.sv
`default_nettype none
package sscm_pkg;

  localparam logic [15:0] TPS_RESET = 16'd1200;
  localparam logic [6:0]  SEC_LIMIT = 7'd60;
  localparam logic [6:0]  HR_LIMIT  = 7'd24;

  typedef enum logic [1:0] {
    EDIT_OFF = 2'd0,
    EDIT_SEC = 2'd1,
    EDIT_MIN = 2'd2,
    EDIT_HR  = 2'd3
  } edit_t;

  localparam logic [2:0] KEY_ENTER = 3'd0;
  localparam logic [2:0] KEY_ESC   = 3'd1;
  localparam logic [2:0] KEY_RIGHT = 3'd2;
  localparam logic [2:0] KEY_UP    = 3'd3;
  localparam logic [2:0] KEY_DOWN  = 3'd4;
  localparam logic [2:0] KEY_LEFT  = 3'd5;

  localparam logic [2:0] LAST_DIGIT = 3'd5;

  localparam logic [1:0] REG_TPS = 2'd0;

  // packed so that the last field, digit_select, lands in the lowest bits
  typedef struct packed {
    edit_t      edit_field;
    logic [5:0] seconds_now;
    logic [5:0] minutes_now;
    logic [4:0] hours_now;
    logic       display_blank;
    logic [6:0] segment_pattern;
    logic [5:0] digit_select;
  } sscm_res_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  function automatic logic [6:0] seg_code(input logic [3:0] v);
    logic [6:0] s;
    case (v)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h3F;
    endcase
    return s;
  endfunction

  function automatic digits_t split_dec(input logic [5:0] v);
    digits_t d;
    if (v >= 6'd60)      d.tens = 4'd6;
    else if (v >= 6'd50) d.tens = 4'd5;
    else if (v >= 6'd40) d.tens = 4'd4;
    else if (v >= 6'd30) d.tens = 4'd3;
    else if (v >= 6'd20) d.tens = 4'd2;
    else if (v >= 6'd10) d.tens = 4'd1;
    else                 d.tens = 4'd0;
    d.units = 4'(v - (6'(d.tens) * 6'd10));
    return d;
  endfunction

  function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [6:0] limit);
    logic [6:0] n;
    n = {1'b0, v} + 7'd1;
    return (n >= limit) ? 6'd0 : n[5:0];
  endfunction

  function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [6:0] limit);
    logic [6:0] m;
    m = limit - 7'd1;
    return (v == 6'd0) ? m[5:0] : v - 6'd1;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sscm_regs.sv
`default_nettype none
module sscm_regs
  import sscm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic      [15:0] tps
);

  logic [15:0] tps_r;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = {1'b0, paddr[2]};
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (wr_en && reg_idx == REG_TPS) begin
      tps_r <= pwdata[15:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TPS: prdata = {16'd0, tps_r};
      default: prdata = 32'd0;
    endcase
  end

  assign tps = tps_r;

endmodule
`default_nettype wire

>>> hw/rtl/sscm_core.sv
`default_nettype none
module sscm_core
  import sscm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic        key,
  input  wire logic [15:0] tps,
  output sscm_res_t        res
);

  logic [15:0] tick_r, tick_nxt, tick_inc;
  logic [4:0]  hr_r, hr_nxt, shr_r, shr_nxt;
  logic [5:0]  min_r, min_nxt, smin_r, smin_nxt;
  logic [5:0]  sec_r, sec_nxt, ssec_r, ssec_nxt;
  edit_t       edit_r, edit_nxt;
  logic [2:0]  digit_r, digit_nxt;
  logic [5:0]  held_r, held_nxt;
  logic [5:0]  field_val;
  digits_t     dec;
  logic [3:0]  shown;
  logic        in_field;
  logic        rising;
  logic [5:0]  hr_up, hr_dn;

  always_comb begin
    digit_nxt = (digit_r >= LAST_DIGIT) ? 3'd0 : digit_r + 3'd1;

    case (digit_nxt[2:1])
      2'd0:    field_val = sec_r;
      2'd1:    field_val = min_r;
      default: field_val = {1'b0, hr_r};
    endcase
    dec   = split_dec(field_val);
    shown = digit_nxt[0] ? dec.tens : dec.units;

    case (edit_r)
      EDIT_SEC: in_field = (digit_nxt[2:1] == 2'd0);
      EDIT_MIN: in_field = (digit_nxt[2:1] == 2'd1);
      EDIT_HR:  in_field = digit_nxt[2];
      default:  in_field = 1'b0;
    endcase

    res.digit_select    = 6'd1 << digit_nxt;
    res.segment_pattern = seg_code(shown);
    res.display_blank   = (edit_r != EDIT_OFF) && (tick_r >= {1'b0, tps[15:1]}) && in_field;

    hr_up = wrap_up({1'b0, hr_r}, HR_LIMIT);
    hr_dn = wrap_down({1'b0, hr_r}, HR_LIMIT);

    hr_nxt   = hr_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    shr_nxt  = shr_r;
    smin_nxt = smin_r;
    ssec_nxt = ssec_r;
    edit_nxt = edit_r;
    held_nxt = held_r;
    held_nxt[digit_nxt] = key;
    rising   = key && !held_r[digit_nxt];

    if (rising) begin
      case (digit_nxt)
        KEY_LEFT: begin
          case (edit_r)
            EDIT_SEC: edit_nxt = EDIT_MIN;
            EDIT_MIN: edit_nxt = EDIT_HR;
            EDIT_HR:  edit_nxt = EDIT_SEC;
            default:  edit_nxt = EDIT_OFF;
          endcase
        end
        KEY_RIGHT: begin
          case (edit_r)
            EDIT_SEC: edit_nxt = EDIT_HR;
            EDIT_MIN: edit_nxt = EDIT_SEC;
            EDIT_HR:  edit_nxt = EDIT_MIN;
            default:  edit_nxt = EDIT_OFF;
          endcase
        end
        KEY_UP: begin
          case (edit_r)
            EDIT_SEC: sec_nxt = wrap_up(sec_r, SEC_LIMIT);
            EDIT_MIN: min_nxt = wrap_up(min_r, SEC_LIMIT);
            EDIT_HR:  hr_nxt  = hr_up[4:0];
            default:  ;
          endcase
        end
        KEY_DOWN: begin
          case (edit_r)
            EDIT_SEC: sec_nxt = wrap_down(sec_r, SEC_LIMIT);
            EDIT_MIN: min_nxt = wrap_down(min_r, SEC_LIMIT);
            EDIT_HR:  hr_nxt  = hr_dn[4:0];
            default:  ;
          endcase
        end
        KEY_ESC: begin
          if (edit_r != EDIT_OFF) begin
            edit_nxt = EDIT_OFF;
            hr_nxt   = shr_r;
            min_nxt  = smin_r;
            sec_nxt  = ssec_r;
          end
        end
        KEY_ENTER: begin
          if (edit_r == EDIT_OFF) begin
            edit_nxt = EDIT_SEC;
            shr_nxt  = hr_r;
            smin_nxt = min_r;
            ssec_nxt = sec_r;
          end else begin
            edit_nxt = EDIT_OFF;
          end
        end
        default: ;
      endcase
    end

    tick_inc = tick_r + 16'd1;
    tick_nxt = tick_inc;
    if (tick_inc >= tps) begin
      tick_nxt = 16'd0;
      if (edit_nxt == EDIT_OFF) begin
        sec_nxt = wrap_up(sec_nxt, SEC_LIMIT);
        if (sec_nxt == 6'd0) begin
          min_nxt = wrap_up(min_nxt, SEC_LIMIT);
          if (min_nxt == 6'd0) begin
            hr_nxt = 5'(wrap_up({1'b0, hr_nxt}, HR_LIMIT));
          end
        end
      end
    end

    res.hours_now   = hr_nxt;
    res.minutes_now = min_nxt;
    res.seconds_now = sec_nxt;
    res.edit_field  = edit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      hr_r    <= '0;
      min_r   <= '0;
      sec_r   <= '0;
      shr_r   <= '0;
      smin_r  <= '0;
      ssec_r  <= '0;
      edit_r  <= EDIT_OFF;
      digit_r <= '0;
      held_r  <= '0;
    end else if (step) begin
      tick_r  <= tick_nxt;
      hr_r    <= hr_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      shr_r   <= shr_nxt;
      smin_r  <= smin_nxt;
      ssec_r  <= ssec_nxt;
      edit_r  <= edit_nxt;
      digit_r <= digit_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/settable_clock_seven_segment_mux.sv
// An accepted transaction moves from the input register to the output register and out_*
// once the output is free. Throughput: one transaction per cycle while out_tready is high;
// the input register refills while a result in the output register waits for out_tready.
// Reset: synchronous, active low; clears time, edit mode, keys and tick count,
// and sets ticks_per_second to 1200.
`default_nettype none
module settable_clock_seven_segment_mux
  import sscm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [0] key_sensed
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,   // [5:0] digit_select, [12:6] segment_pattern,
                                        // [13] display_blank, [18:14] hours_now,
                                        // [24:19] minutes_now, [30:25] seconds_now,
                                        // [32:31] edit_field
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  logic        in_vld_r;
  logic        key_r;
  logic        out_vld_r;
  sscm_res_t   res;
  sscm_res_t   res_r;
  logic        adv;
  logic [15:0] tps;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      key_r <= in_tdata[0];
    end
    if (adv) begin
      res_r <= res;
    end
  end

  sscm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .tps     (tps)
  );

  sscm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .key   (key_r),
    .tps   (tps),
    .res   (res)
  );

  assign cfg_pready = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, res_r};

endmodule
`default_nettype wire

>>> hw/rtl/sscm_chk.sv
`default_nettype none
`include "settable_clock_seven_segment_mux_assert.svh"
module sscm_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  `SSCM_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "out_tvalid dropped while stalled")
  `SSCM_ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "out_tdata changed while stalled")
  `SSCM_ASSERT_IMP(a_sel_onehot, clk, rst_n, out_tvalid, $onehot(out_tdata[5:0]), "digit select not one-hot")
  `SSCM_ASSERT_IMP(a_time_range, clk, rst_n, out_tvalid, out_tdata[18:14] <= 5'd23 && out_tdata[24:19] <= 6'd59 && out_tdata[30:25] <= 6'd59, "time out of range")

endmodule

bind settable_clock_seven_segment_mux sscm_chk u_chk (.*);
`default_nettype wire

>>> tb/sv/settable_clock_seven_segment_mux_tb.sv
`timescale 1ns / 1ps
module settable_clock_seven_segment_mux_tb;
  import sscm_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned PRINT_CAP   = 100;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [7:0]  in_tdata    = '0;
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [39:0] out_tdata;
  wire  [31:0] cfg_prdata;
  wire         cfg_pready;

  settable_clock_seven_segment_mux i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // clock model
  logic [6:0]  seg_font [0:9] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                  7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
  logic [15:0] rate_reg   = TPS_RESET;
  logic [15:0] tick_cnt   = '0;
  logic [4:0]  hrs        = '0;
  logic [5:0]  mins       = '0;
  logic [5:0]  secs       = '0;
  logic [4:0]  saved_hrs  = '0;
  logic [5:0]  saved_mins = '0;
  logic [5:0]  saved_secs = '0;
  edit_t       edit_mode  = EDIT_OFF;
  logic [2:0]  digit      = '0;
  logic [5:0]  keys_down  = '0;

  sscm_res_t   clock_results [$];
  int unsigned ticks_sent   = 0;
  int unsigned mismatches   = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;
  bit          steady       = 1'b0;

  function automatic logic [5:0] roll_up(input logic [5:0] v, input logic [6:0] lim);
    logic [6:0] n;
    n = {1'b0, v} + 7'd1;
    return (n >= lim) ? 6'd0 : n[5:0];
  endfunction

  function automatic logic [5:0] roll_down(input logic [5:0] v, input logic [6:0] lim);
    logic [6:0] m;
    m = lim - 7'd1;
    return (v == 6'd0) ? m[5:0] : v - 6'd1;
  endfunction

  function automatic sscm_res_t step_clock(input logic key);
    sscm_res_t  r;
    logic [5:0] sel;
    logic [5:0] val;
    logic       field_hit;
    logic       rising;
    digit = (digit >= LAST_DIGIT) ? 3'd0 : digit + 3'd1;
    sel = 6'd1 << digit;
    case (digit)
      3'd0, 3'd1: val = secs;
      3'd2, 3'd3: val = mins;
      default: val = {1'b0, hrs};
    endcase
    r.segment_pattern = seg_font[digit[0] ? (val / 6'd10) % 6'd10 : val % 6'd10];
    case (edit_mode)
      EDIT_SEC: field_hit = (digit <= 3'd1);
      EDIT_MIN: field_hit = (digit == 3'd2) || (digit == 3'd3);
      EDIT_HR:  field_hit = (digit >= 3'd4);
      default:  field_hit = 1'b0;
    endcase
    r.display_blank = (edit_mode != EDIT_OFF) && (tick_cnt >= (rate_reg >> 1)) && field_hit;

    if (key) begin
      rising = ((keys_down & sel) == 6'd0);
      keys_down = keys_down | sel;
      if (rising) begin
        case (digit)
          KEY_LEFT: begin
            case (edit_mode)
              EDIT_SEC: edit_mode = EDIT_MIN;
              EDIT_MIN: edit_mode = EDIT_HR;
              EDIT_HR:  edit_mode = EDIT_SEC;
              default: ;
            endcase
          end
          KEY_RIGHT: begin
            case (edit_mode)
              EDIT_SEC: edit_mode = EDIT_HR;
              EDIT_MIN: edit_mode = EDIT_SEC;
              EDIT_HR:  edit_mode = EDIT_MIN;
              default: ;
            endcase
          end
          KEY_UP, KEY_DOWN: begin
            case (edit_mode)
              EDIT_SEC: secs = (digit == KEY_UP) ? roll_up(secs, SEC_LIMIT)
                                                 : roll_down(secs, SEC_LIMIT);
              EDIT_MIN: mins = (digit == KEY_UP) ? roll_up(mins, SEC_LIMIT)
                                                 : roll_down(mins, SEC_LIMIT);
              EDIT_HR:  hrs = (digit == KEY_UP) ? 5'(roll_up({1'b0, hrs}, HR_LIMIT))
                                                : 5'(roll_down({1'b0, hrs}, HR_LIMIT));
              default: ;
            endcase
          end
          KEY_ESC: begin
            if (edit_mode != EDIT_OFF) begin
              edit_mode = EDIT_OFF;
              hrs  = saved_hrs;
              mins = saved_mins;
              secs = saved_secs;
            end
          end
          default: begin
            if (edit_mode == EDIT_OFF) begin
              edit_mode  = EDIT_SEC;
              saved_hrs  = hrs;
              saved_mins = mins;
              saved_secs = secs;
            end else begin
              edit_mode = EDIT_OFF;
            end
          end
        endcase
      end
    end else begin
      keys_down = keys_down & ~sel;
    end

    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= rate_reg) begin
      tick_cnt = '0;
      if (edit_mode == EDIT_OFF) begin
        secs = roll_up(secs, SEC_LIMIT);
        if (secs == 6'd0) begin
          mins = roll_up(mins, SEC_LIMIT);
          if (mins == 6'd0) hrs = 5'(roll_up({1'b0, hrs}, HR_LIMIT));
        end
      end
    end

    r.digit_select = sel;
    r.hours_now    = hrs;
    r.minutes_now  = mins;
    r.seconds_now  = secs;
    r.edit_field   = edit_mode;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // receiver: random stalls, or a counted hold-off when requested
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    sscm_res_t got;
    sscm_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = sscm_res_t'(out_tdata[32:0]);
      if (clock_results.size() == 0) begin
        note_mismatch("result with nothing pending", out_tdata[31:0], 32'd0);
      end else begin
        want = clock_results.pop_front();
        if (got.digit_select != want.digit_select)
          note_mismatch("digit_select", 32'(got.digit_select), 32'(want.digit_select));
        if (got.segment_pattern != want.segment_pattern)
          note_mismatch("segment_pattern", 32'(got.segment_pattern),
                        32'(want.segment_pattern));
        if (got.display_blank != want.display_blank)
          note_mismatch("display_blank", 32'(got.display_blank), 32'(want.display_blank));
        if (got.hours_now != want.hours_now)
          note_mismatch("hours_now", 32'(got.hours_now), 32'(want.hours_now));
        if (got.minutes_now != want.minutes_now)
          note_mismatch("minutes_now", 32'(got.minutes_now), 32'(want.minutes_now));
        if (got.seconds_now != want.seconds_now)
          note_mismatch("seconds_now", 32'(got.seconds_now), 32'(want.seconds_now));
        if (got.edit_field != want.edit_field)
          note_mismatch("edit_field", 32'(got.edit_field), 32'(want.edit_field));
        if (out_tdata[39:33] != 7'd0)
          note_mismatch("out_tdata padding", 32'(out_tdata[39:33]), 32'd0);
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("settable_clock_seven_segment_mux: mismatch");
    $finish;
  end

  task automatic send_tick(input logic key);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    clock_results.push_back(step_clock(key));
    ticks_sent++;
  endtask

  // advance to the key's column and press it; optionally release it first
  task automatic press_key(input logic [2:0] col, input bit keep_held, input bit noisy);
    if (!keep_held)
      while (keys_down[col]) send_tick(1'b0);
    while (((digit >= LAST_DIGIT) ? 3'd0 : digit + 3'd1) != col)
      send_tick(noisy && ($urandom_range(99) < 5));
    send_tick(1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (clock_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_reg(input logic [1:0] idx, output logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 3'(4 * idx);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    value = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic program_ticks_per_second(input logic [15:0] value);
    logic [31:0] readback;
    wait_drained();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 3'(4 * REG_TPS);
    cfg_pwdata  <= {16'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rate_reg = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    read_reg(REG_TPS, readback);
    if (readback != {16'd0, value})
      note_mismatch("ticks_per_second readback", readback, {16'd0, value});
  endtask

  task automatic random_key_op();
    int unsigned pick;
    logic [2:0]  col;
    pick = $urandom_range(99);
    if (pick < 75) begin
      pick = $urandom_range(99);
      if (pick < 15)      col = KEY_ENTER;
      else if (pick < 23) col = KEY_ESC;
      else if (pick < 38) col = KEY_LEFT;
      else if (pick < 53) col = KEY_RIGHT;
      else if (pick < 76) col = KEY_UP;
      else                col = KEY_DOWN;
      press_key(col, $urandom_range(99) < 20, 1'b1);
    end else begin
      repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
    end
  endtask

  task automatic test_reset_defaults();
    logic [31:0] readback;
    read_reg(REG_TPS, readback);
    if (readback != {16'd0, TPS_RESET})
      note_mismatch("ticks_per_second after reset", readback, {16'd0, TPS_RESET});
    repeat (30) send_tick(1'b0);
  endtask

  task automatic test_keys_directed();
    program_ticks_per_second(16'd2);
    repeat (12) send_tick(1'b0);
    // navigation and adjust keys do nothing with edit off
    press_key(KEY_LEFT, 1'b0, 1'b0);
    press_key(KEY_RIGHT, 1'b0, 1'b0);
    press_key(KEY_UP, 1'b0, 1'b0);
    press_key(KEY_DOWN, 1'b0, 1'b0);
    press_key(KEY_ESC, 1'b0, 1'b0);
    // wrap hours and minutes down to 23:59, adjust the seconds, cycle the fields both ways, keep it
    press_key(KEY_ENTER, 1'b0, 1'b0);
    press_key(KEY_DOWN, 1'b0, 1'b0);
    press_key(KEY_LEFT, 1'b0, 1'b0);
    press_key(KEY_DOWN, 1'b0, 1'b0);
    press_key(KEY_LEFT, 1'b0, 1'b0);
    press_key(KEY_DOWN, 1'b0, 1'b0);
    press_key(KEY_LEFT, 1'b0, 1'b0);
    press_key(KEY_RIGHT, 1'b0, 1'b0);
    press_key(KEY_RIGHT, 1'b0, 1'b0);
    press_key(KEY_RIGHT, 1'b0, 1'b0);
    press_key(KEY_UP, 1'b0, 1'b0);
    press_key(KEY_DOWN, 1'b0, 1'b0);
    press_key(KEY_ENTER, 1'b0, 1'b0);
    // clock runs on from the set time
    repeat (8) send_tick(1'b0);
    // escape restores the saved time
    press_key(KEY_ENTER, 1'b0, 1'b0);
    press_key(KEY_UP, 1'b0, 1'b0);
    press_key(KEY_UP, 1'b0, 1'b0);
    press_key(KEY_ESC, 1'b0, 1'b0);
    // held keys act once
    repeat (18) send_tick(1'b1);
    repeat (12) send_tick(1'b0);
  endtask

  task automatic test_random_keys();
    logic [15:0] rates   [8];
    int unsigned budgets [8];
    int unsigned start;
    rates   = '{16'd5, 16'd3, 16'd2, 16'd17, 16'd65535, 16'd1200,
                16'($urandom_range(2, 40)), 16'($urandom_range(6, 300))};
    budgets = '{140, 140, 140, 140, 100, 120, 140, 140};
    for (int i = 0; i < 8; i++) begin
      program_ticks_per_second(rates[i]);
      steady = (i == 0);
      start = ticks_sent;
      while (ticks_sent - start < budgets[i]) random_key_op();
      steady = 1'b0;
    end
  endtask

  task automatic test_output_stall();
    program_ticks_per_second(16'd3);
    stall_left = 300;
    repeat (80) random_key_op();
  endtask

  task automatic test_drain_pause();
    program_ticks_per_second(16'd4);
    repeat (40) random_key_op();
    wait_drained();
    repeat (40) random_key_op();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_keys_directed();
    test_random_keys();
    test_output_stall();
    test_drain_pause();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("settable_clock_seven_segment_mux: match");
    else
      $display("settable_clock_seven_segment_mux: mismatch");
    $finish;
  end

endmodule
